[rtl/scrc_pkg.sv]
// Shared types and constants of the screen rectangle polygon clipper.
// Used by every module of the clipper; no dependencies of its own.
package scrc_pkg;

    // Default coordinate width (signed fixed point)
    localparam int COORD_WIDTH_DEF = 32;
    // Width of each clip register and of the write data
    localparam int CFG_WIDTH = 32;
    localparam int CFG_IDX_W = 2;
    // Clip stages, stage code width (one extra code for the output side)
    localparam int NUM_STAGES = 4;
    localparam int STAGE_W = 3;
    // Depth of the work stack in the back end
    localparam int STACK_DEPTH = 8;
    localparam int COUNT_W = 8;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT,
        CFG_RIGHT,
        CFG_TOP,
        CFG_BOTTOM
    } cfg_idx_t;

    // Stage codes, in processing order
    localparam logic [1:0] STAGE_TOP    = 2'd0;
    localparam logic [1:0] STAGE_RIGHT  = 2'd1;
    localparam logic [1:0] STAGE_BOTTOM = 2'd2;
    localparam logic [1:0] STAGE_LEFT   = 2'd3;

    // Input command and result kind codes
    localparam logic CMD_FLUSH   = 1'b1;
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_END    = 1'b1;

    // Register reset values
    localparam logic signed [CFG_WIDTH-1:0] RST_LEFT   = 32'sd0;
    localparam logic signed [CFG_WIDTH-1:0] RST_RIGHT  = 32'sd20905984;
    localparam logic signed [CFG_WIDTH-1:0] RST_TOP    = 32'sd0;
    localparam logic signed [CFG_WIDTH-1:0] RST_BOTTOM = 32'sd13041664;

    typedef struct packed {
        logic signed [CFG_WIDTH-1:0] clip_left;
        logic signed [CFG_WIDTH-1:0] clip_right;
        logic signed [CFG_WIDTH-1:0] clip_top;
        logic signed [CFG_WIDTH-1:0] clip_bottom;
    } clip_cfg_t;

    // Queue head status from front to back
    typedef struct packed {
        logic valid;
        logic flush;
    } queue_ctl_t;

endpackage

[rtl/scrc_front.sv]
// Front end: accepts input items, classifies vertex or flush, and queues them.
// Depends on scrc_pkg.
module scrc_front #(
    parameter int COORD_WIDTH = scrc_pkg::COORD_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                       s_tuser,
    output scrc_pkg::queue_ctl_t       q_ctl,
    output logic [COORD_WIDTH-1:0]     q_x,
    output logic [COORD_WIDTH-1:0]     q_y,
    output logic [COORD_WIDTH-1:0]     q_z,
    input  logic                       q_ready
);
    import scrc_pkg::*;

    localparam int W = COORD_WIDTH;

    logic         flush_reg [2];
    logic [W-1:0] x_reg [2];
    logic [W-1:0] y_reg [2];
    logic [W-1:0] z_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   fill_reg, fill_next;
    logic         push, pop;

    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_ctl.valid && q_ready;

    // Present the queue head
    assign q_ctl.valid = (fill_reg != 2'd0);
    assign q_ctl.flush = flush_reg[rd_ptr_reg];
    assign q_x         = x_reg[rd_ptr_reg];
    assign q_y         = y_reg[rd_ptr_reg];
    assign q_z         = z_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Classify and store the accepted item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            flush_reg[wr_ptr_reg] <= (s_tuser == CMD_FLUSH);
            x_reg[wr_ptr_reg]     <= s_tdata[W-1:0];
            y_reg[wr_ptr_reg]     <= s_tdata[2*W-1:W];
            z_reg[wr_ptr_reg]     <= s_tdata[3*W-1:2*W];
        end
    end

endmodule

[rtl/scrc_muldiv.sv]
// Sequential c + a * b / d unit: shift-add multiply, restoring divide,
// clamped quotient and saturating sum. Depends on scrc_pkg.
module scrc_muldiv #(
    parameter int COORD_WIDTH = scrc_pkg::COORD_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic signed [((COORD_WIDTH > scrc_pkg::CFG_WIDTH) ?
                          COORD_WIDTH : scrc_pkg::CFG_WIDTH)-1:0] cbase,
    input  logic signed [((COORD_WIDTH > scrc_pkg::CFG_WIDTH) ?
                          COORD_WIDTH : scrc_pkg::CFG_WIDTH):0] num1,
    input  logic signed [((COORD_WIDTH > scrc_pkg::CFG_WIDTH) ?
                          COORD_WIDTH : scrc_pkg::CFG_WIDTH):0] num2,
    input  logic signed [((COORD_WIDTH > scrc_pkg::CFG_WIDTH) ?
                          COORD_WIDTH : scrc_pkg::CFG_WIDTH):0] den,
    output logic done,
    output logic signed [((COORD_WIDTH > scrc_pkg::CFG_WIDTH) ?
                          COORD_WIDTH : scrc_pkg::CFG_WIDTH)-1:0] result
);
    import scrc_pkg::*;

    localparam int VW    = (COORD_WIDTH > CFG_WIDTH) ? COORD_WIDTH : CFG_WIDTH;
    localparam int PW    = 2 * VW;
    localparam int CNT_W = $clog2(PW);
    localparam longint SAT_HI_L = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam logic signed [VW+2:0] SAT_HI = (VW+3)'(SAT_HI_L);
    localparam logic signed [VW+2:0] SAT_LO = (VW+3)'(-SAT_HI_L - 1);
    localparam logic [VW+1:0] Q_CLAMP = {1'b1, {(VW+1){1'b0}}};

    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_FIN} md_state_t;

    md_state_t             state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [PW-1:0]         mcand_reg;
    logic [VW-1:0]         mplier_reg;
    logic [PW-1:0]         acc_reg;
    logic [VW-1:0]         rem_reg;
    logic [VW-1:0]         dvs_reg;
    logic                  neg_reg;
    logic signed [VW-1:0]  cbase_reg;
    logic signed [VW-1:0]  result_reg;
    logic                  done_reg;

    logic [VW:0]           mag1, mag2, magd;
    logic [VW:0]           trial;
    logic                  ge;
    logic [VW+1:0]         qc;
    logic signed [VW+2:0]  sq, sum, sat;

    // Magnitudes of the operands
    always_comb
    begin
        mag1 = num1[VW] ? (VW+1)'(-num1) : num1;
        mag2 = num2[VW] ? (VW+1)'(-num2) : num2;
        magd = den[VW] ? (VW+1)'(-den) : den;
    end

    // One restoring division step
    assign trial = {rem_reg, acc_reg[PW-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    // Clamp the quotient, apply sign, add and saturate
    always_comb
    begin
        qc  = (|acc_reg[PW-1:VW+1]) ? Q_CLAMP : acc_reg[VW+1:0];
        sq  = neg_reg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        sum = (VW+3)'(cbase_reg) + sq;
        if (sum > SAT_HI)
            sat = SAT_HI;
        else if (sum < SAT_LO)
            sat = SAT_LO;
        else
            sat = sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MD_IDLE:
                begin
                    if (start)
                    begin
                        cbase_reg  <= cbase;
                        mcand_reg  <= PW'(mag1[VW-1:0]);
                        mplier_reg <= mag2[VW-1:0];
                        dvs_reg    <= magd[VW-1:0];
                        neg_reg    <= num1[VW] ^ num2[VW] ^ den[VW];
                        acc_reg    <= '0;
                        rem_reg    <= '0;
                        cnt_reg    <= '0;
                        if (den == '0)
                        begin
                            // parallel edge: keep the base coordinate
                            result_reg <= cbase;
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= MD_MUL;
                        end
                    end
                end
                MD_MUL:
                begin
                    if (mplier_reg[0])
                        acc_reg <= acc_reg + mcand_reg;
                    mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[VW-1:1]};
                    if (cnt_reg == CNT_W'(VW - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= MD_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                MD_DIV:
                begin
                    rem_reg <= ge ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
                    acc_reg <= {acc_reg[PW-2:0], ge};
                    if (cnt_reg == CNT_W'(PW - 1))
                        state_reg <= MD_FIN;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                MD_FIN:
                begin
                    result_reg <= VW'(sat);
                    done_reg   <= 1'b1;
                    state_reg  <= MD_IDLE;
                end
                default:
                begin
                    state_reg <= MD_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/scrc_back.sv]
// Back end: runs the four clip stages over a work stack, computes
// intersections and holds the result register. Depends on scrc_pkg, scrc_muldiv.
module scrc_back #(
    parameter int COORD_WIDTH = scrc_pkg::COORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  scrc_pkg::clip_cfg_t              cfg,
    input  scrc_pkg::queue_ctl_t             q_ctl,
    input  logic [COORD_WIDTH-1:0]           q_x,
    input  logic [COORD_WIDTH-1:0]           q_y,
    input  logic [COORD_WIDTH-1:0]           q_z,
    output logic                             q_ready,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_kind,
    output logic                             out_last,
    output logic [COORD_WIDTH-1:0]           out_x,
    output logic [COORD_WIDTH-1:0]           out_y,
    output logic [COORD_WIDTH-1:0]           out_z,
    output logic [scrc_pkg::COUNT_W-1:0]     out_count
);
    import scrc_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int VW    = (W > CFG_WIDTH) ? W : CFG_WIDTH;
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam logic [STAGE_W-1:0] OUT_STAGE = STAGE_W'(NUM_STAGES);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {ST_IDLE, ST_POP, ST_FLUSH, ST_CROSS_Z, ST_CROSS_C} state_t;

    // control
    state_t               state_reg, state_next;
    logic                 flushing_reg, flushing_next;
    logic [STAGE_W-1:0]   fs_reg, fs_next;
    logic [SP_W-1:0]      sp_reg, sp_next;
    logic                 md_wait_reg, md_wait_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic [NUM_STAGES-1:0] has_first_reg, has_first_next;

    // work stack
    logic [STAGE_W-1:0]   stk_stage_reg [STACK_DEPTH];
    logic signed [VW-1:0] stk_x_reg [STACK_DEPTH];
    logic signed [VW-1:0] stk_y_reg [STACK_DEPTH];
    logic signed [VW-1:0] stk_z_reg [STACK_DEPTH];

    // per-stage first and previous vertex
    logic signed [VW-1:0] first_x_reg [NUM_STAGES];
    logic signed [VW-1:0] first_y_reg [NUM_STAGES];
    logic signed [VW-1:0] first_z_reg [NUM_STAGES];
    logic signed [VW-1:0] prev_x_reg [NUM_STAGES];
    logic signed [VW-1:0] prev_y_reg [NUM_STAGES];
    logic signed [VW-1:0] prev_z_reg [NUM_STAGES];

    // intersection operands
    logic [1:0]           cs_reg;
    logic signed [VW-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [VW-1:0] rz_reg;

    // pending result and output register
    logic signed [VW-1:0] pend_x_reg, pend_y_reg, pend_z_reg;
    logic [COUNT_W-1:0]   pend_count_reg;
    logic                 out_kind_reg, out_last_reg;
    logic [W-1:0]         out_x_reg, out_y_reg, out_z_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    // combinational controls
    logic [IDX_W-1:0]     top_idx;
    logic [STAGE_W-1:0]   top_stage;
    logic signed [VW-1:0] top_x, top_y, top_z;
    logic [1:0]           rd_idx;
    logic                 hf;
    logic signed [VW-1:0] fx, fy, fz, px, py, pz;
    logic                 in_now, in_prev, in_first_f, in_prev_f;
    logic                 stack_empty, out_free;
    logic                 push, pop;
    logic [STAGE_W-1:0]   push_stage;
    logic signed [VW-1:0] push_x, push_y, push_z;
    logic [IDX_W-1:0]     waddr;
    logic                 prev_we, first_we;
    logic                 latch_ops;
    logic [1:0]           ops_stage;
    logic signed [VW-1:0] ops_ax, ops_ay, ops_az, ops_bx, ops_by, ops_bz;
    logic                 rz_we;
    logic                 pend_load;
    logic [COUNT_W-1:0]   cnt_inc;
    logic                 out_load, out_load_kind, out_load_last, out_from_pend;

    // intersection datapath
    logic                 horiz, base_b;
    logic signed [VW-1:0] edge_v, pa, pb, pbase, poth, cbase, coth;
    logic signed [VW:0]   num1, num2, den;
    logic                 md_start, md_done;
    logic signed [VW-1:0] md_result;

    function automatic logic inside_f(input logic [1:0] stage,
                                      input logic signed [VW-1:0] x,
                                      input logic signed [VW-1:0] y,
                                      input clip_cfg_t c);
        logic r;
        unique case (stage)
            STAGE_TOP:    r = !(y < VW'(c.clip_top));
            STAGE_RIGHT:  r = !(x > VW'(c.clip_right));
            STAGE_BOTTOM: r = !(y > VW'(c.clip_bottom));
            STAGE_LEFT:   r = !(x < VW'(c.clip_left));
        endcase
        return r;
    endfunction

    // Stack top and stage store read port
    assign top_idx     = IDX_W'(sp_reg - 1'b1);
    assign top_stage   = stk_stage_reg[top_idx];
    assign top_x       = stk_x_reg[top_idx];
    assign top_y       = stk_y_reg[top_idx];
    assign top_z       = stk_z_reg[top_idx];
    assign stack_empty = (sp_reg == '0);
    assign rd_idx      = (state_reg == ST_FLUSH) ? fs_reg[1:0] : top_stage[1:0];
    assign hf          = has_first_reg[rd_idx];
    assign fx          = first_x_reg[rd_idx];
    assign fy          = first_y_reg[rd_idx];
    assign fz          = first_z_reg[rd_idx];
    assign px          = prev_x_reg[rd_idx];
    assign py          = prev_y_reg[rd_idx];
    assign pz          = prev_z_reg[rd_idx];
    assign in_now      = inside_f(top_stage[1:0], top_x, top_y, cfg);
    assign in_prev     = inside_f(top_stage[1:0], px, py, cfg);
    assign in_first_f  = inside_f(fs_reg[1:0], fx, fy, cfg);
    assign in_prev_f   = inside_f(fs_reg[1:0], px, py, cfg);
    assign out_free    = !out_valid_reg || out_ready;
    assign cnt_inc     = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;

    // Pick the crossed axis, edge and fixed interpolation direction
    always_comb
    begin
        horiz = (cs_reg == STAGE_TOP) || (cs_reg == STAGE_BOTTOM);
        unique case (cs_reg)
            STAGE_TOP:    edge_v = VW'(cfg.clip_top);
            STAGE_RIGHT:  edge_v = VW'(cfg.clip_right);
            STAGE_BOTTOM: edge_v = VW'(cfg.clip_bottom);
            STAGE_LEFT:   edge_v = VW'(cfg.clip_left);
        endcase
        pa     = horiz ? ay_reg : ax_reg;
        pb     = horiz ? by_reg : bx_reg;
        base_b = (pa < pb);
        pbase  = base_b ? pb : pa;
        poth   = base_b ? pa : pb;
        if (state_reg == ST_CROSS_Z)
        begin
            cbase = base_b ? bz_reg : az_reg;
            coth  = base_b ? az_reg : bz_reg;
        end
        else if (horiz)
        begin
            cbase = base_b ? bx_reg : ax_reg;
            coth  = base_b ? ax_reg : bx_reg;
        end
        else
        begin
            cbase = base_b ? by_reg : ay_reg;
            coth  = base_b ? ay_reg : by_reg;
        end
        num1 = (VW+1)'(coth) - (VW+1)'(cbase);
        num2 = (VW+1)'(edge_v) - (VW+1)'(pbase);
        den  = (VW+1)'(poth) - (VW+1)'(pbase);
    end

    assign md_start = ((state_reg == ST_CROSS_Z) || (state_reg == ST_CROSS_C)) && !md_wait_reg;

    scrc_muldiv #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .cbase  (cbase),
        .num1   (num1),
        .num2   (num2),
        .den    (den),
        .done   (md_done),
        .result (md_result)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        flushing_next   = flushing_reg;
        fs_next         = fs_reg;
        md_wait_next    = md_wait_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        has_first_next  = has_first_reg;
        q_ready         = 1'b0;
        push            = 1'b0;
        pop             = 1'b0;
        push_stage      = top_stage + 1'b1;
        push_x          = top_x;
        push_y          = top_y;
        push_z          = top_z;
        prev_we         = 1'b0;
        first_we        = 1'b0;
        latch_ops       = 1'b0;
        ops_stage       = top_stage[1:0];
        ops_ax          = top_x;
        ops_ay          = top_y;
        ops_az          = top_z;
        ops_bx          = px;
        ops_by          = py;
        ops_bz          = pz;
        rz_we           = 1'b0;
        pend_load       = 1'b0;
        out_load        = 1'b0;
        out_load_kind   = KIND_VERTEX;
        out_load_last   = 1'b0;
        out_from_pend   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_ctl.valid)
                begin
                    q_ready = 1'b1;
                    if (q_ctl.flush)
                    begin
                        flushing_next = 1'b1;
                        fs_next       = '0;
                        state_next    = ST_FLUSH;
                    end
                    else
                    begin
                        push       = 1'b1;
                        push_stage = '0;
                        push_x     = VW'($signed(q_x));
                        push_y     = VW'($signed(q_y));
                        push_z     = VW'($signed(q_z));
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP:
            begin
                if (stack_empty)
                begin
                    if (flushing_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (!pend_valid_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        // last result of this vertex
                        out_load        = 1'b1;
                        out_load_last   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else if (top_stage == OUT_STAGE)
                begin
                    // vertex leaves the last stage: hold it, send the older one
                    if (!pend_valid_reg || out_free)
                    begin
                        out_load        = pend_valid_reg;
                        pend_load       = 1'b1;
                        pend_valid_next = 1'b1;
                        count_next      = cnt_inc;
                        pop             = 1'b1;
                    end
                end
                else
                begin
                    pop     = 1'b1;
                    prev_we = 1'b1;
                    push    = in_now;
                    if (!hf)
                    begin
                        first_we = 1'b1;
                        has_first_next[top_stage[1:0]] = 1'b1;
                    end
                    else if (in_now != in_prev)
                    begin
                        latch_ops  = 1'b1;
                        state_next = ST_CROSS_Z;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (fs_reg == OUT_STAGE)
                begin
                    if (pend_valid_reg)
                    begin
                        if (out_free)
                        begin
                            out_load        = 1'b1;
                            pend_valid_next = 1'b0;
                        end
                    end
                    else if (out_free)
                    begin
                        // end item closes the polygon
                        out_load       = 1'b1;
                        out_from_pend  = 1'b0;
                        out_load_kind  = KIND_END;
                        out_load_last  = 1'b1;
                        has_first_next = '0;
                        count_next     = '0;
                        flushing_next  = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    fs_next = fs_reg + 1'b1;
                    if (hf && (in_first_f != in_prev_f))
                    begin
                        latch_ops  = 1'b1;
                        ops_stage  = fs_reg[1:0];
                        ops_ax     = fx;
                        ops_ay     = fy;
                        ops_az     = fz;
                        state_next = ST_CROSS_Z;
                    end
                end
            end
            ST_CROSS_Z:
            begin
                if (!md_wait_reg)
                begin
                    md_wait_next = 1'b1;
                end
                else if (md_done)
                begin
                    rz_we        = 1'b1;
                    md_wait_next = 1'b0;
                    state_next   = ST_CROSS_C;
                end
            end
            ST_CROSS_C:
            begin
                if (!md_wait_reg)
                begin
                    md_wait_next = 1'b1;
                end
                else if (md_done)
                begin
                    md_wait_next = 1'b0;
                    push         = 1'b1;
                    push_stage   = STAGE_W'(cs_reg) + 1'b1;
                    push_z       = rz_reg;
                    push_x       = horiz ? md_result : edge_v;
                    push_y       = horiz ? edge_v : md_result;
                    state_next   = ST_POP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        sp_next        = sp_reg + SP_W'(push) - SP_W'(pop);
        waddr          = pop ? top_idx : sp_reg[IDX_W-1:0];
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            flushing_reg   <= 1'b0;
            fs_reg         <= '0;
            sp_reg         <= '0;
            md_wait_reg    <= 1'b0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            has_first_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            flushing_reg   <= flushing_next;
            fs_reg         <= fs_next;
            sp_reg         <= sp_next;
            md_wait_reg    <= md_wait_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            has_first_reg  <= has_first_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stk_stage_reg[waddr] <= push_stage;
            stk_x_reg[waddr]     <= push_x;
            stk_y_reg[waddr]     <= push_y;
            stk_z_reg[waddr]     <= push_z;
        end
        if (prev_we)
        begin
            prev_x_reg[top_stage[1:0]] <= top_x;
            prev_y_reg[top_stage[1:0]] <= top_y;
            prev_z_reg[top_stage[1:0]] <= top_z;
        end
        if (first_we)
        begin
            first_x_reg[top_stage[1:0]] <= top_x;
            first_y_reg[top_stage[1:0]] <= top_y;
            first_z_reg[top_stage[1:0]] <= top_z;
        end
        if (latch_ops)
        begin
            cs_reg <= ops_stage;
            ax_reg <= ops_ax;
            ay_reg <= ops_ay;
            az_reg <= ops_az;
            bx_reg <= ops_bx;
            by_reg <= ops_by;
            bz_reg <= ops_bz;
        end
        if (rz_we)
            rz_reg <= md_result;
        if (pend_load)
        begin
            pend_x_reg     <= top_x;
            pend_y_reg     <= top_y;
            pend_z_reg     <= top_z;
            pend_count_reg <= cnt_inc;
        end
        if (out_load)
        begin
            out_kind_reg  <= out_load_kind;
            out_last_reg  <= out_load_last;
            out_x_reg     <= out_from_pend ? pend_x_reg[W-1:0] : '0;
            out_y_reg     <= out_from_pend ? pend_y_reg[W-1:0] : '0;
            out_z_reg     <= out_from_pend ? pend_z_reg[W-1:0] : '0;
            out_count_reg <= out_from_pend ? pend_count_reg : count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign out_count = out_count_reg;

endmodule

[rtl/screen_rect_polygon_clipper_unit.sv]
// Top level of the screen rectangle polygon clipper: clip registers and stream ports.
// Depends on scrc_pkg, scrc_front, scrc_back (which uses scrc_muldiv).
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+----------------------------------
//  s_axis    | in        | s_axis_tvalid/tready   | tuser cmd, tdata x y z
//  m_axis    | out       | m_axis_tvalid/tready   | tuser kind, tlast, tdata x y z count
//  cfg       | in        | cfg_we (always taken)  | cfg_index, cfg_wdata
//
// Each intersection runs the multiply-divide unit twice, first for z and then for the
// other coordinate along the crossed edge.
// Reset is asynchronous and clears the polygon state; the clip registers return to
// their defaults. A two-entry queue takes input while the back end works, and the
// back end stops only when a result is ready and the output register is full.
module screen_rect_polygon_clipper_unit #(
    parameter int COORD_WIDTH = scrc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // slave stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // vertex_x, vertex_y, vertex_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // cmd
    input  logic                                  s_axis_tuser,
    // master stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_x, out_y, out_z, vertex_count
    output logic [((3*COORD_WIDTH+15)/8)*8-1:0]   m_axis_tdata,
    // out_kind
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [scrc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [scrc_pkg::CFG_WIDTH-1:0]        cfg_wdata
);
    import scrc_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int OUT_DW = ((3*W+15)/8)*8;

    clip_cfg_t          cfg_reg, cfg_next;
    queue_ctl_t         q_ctl;
    logic [W-1:0]       q_x, q_y, q_z;
    logic               q_ready;
    logic [W-1:0]       out_x, out_y, out_z;
    logic [COUNT_W-1:0] out_count;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LEFT:   cfg_next.clip_left   = cfg_wdata;
                CFG_RIGHT:  cfg_next.clip_right  = cfg_wdata;
                CFG_TOP:    cfg_next.clip_top    = cfg_wdata;
                CFG_BOTTOM: cfg_next.clip_bottom = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_left   <= RST_LEFT;
            cfg_reg.clip_right  <= RST_RIGHT;
            cfg_reg.clip_top    <= RST_TOP;
            cfg_reg.clip_bottom <= RST_BOTTOM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    scrc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .q_ctl    (q_ctl),
        .q_x      (q_x),
        .q_y      (q_y),
        .q_z      (q_z),
        .q_ready  (q_ready)
    );

    scrc_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_ctl     (q_ctl),
        .q_x       (q_x),
        .q_y       (q_y),
        .q_z       (q_z),
        .q_ready   (q_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_count (out_count)
    );

    // Pack the result fields, lowest first, zero padded
    assign m_axis_tdata = OUT_DW'({out_count, out_z, out_y, out_x});

endmodule
